[hdl/htd_pkg.sv]
// htd_pkg: shared types, constants and helpers for the huffman tree loader and decoder
// no dependencies; compiled first

package htd_pkg;

    localparam int NODE_DEPTH  = 511;
    localparam int STACK_DEPTH = 256;
    localparam int NODE_AW     = $clog2(NODE_DEPTH);
    localparam int NODE_CW     = $clog2(NODE_DEPTH + 1);
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int STACK_LW    = $clog2(STACK_DEPTH + 1);
    localparam int SYM_W       = 8;
    localparam int BITS_W      = 4;
    localparam int BYTE_BITS   = 8;

    localparam logic [SYM_W-1:0] TAG_LEAF = 8'h31;
    localparam logic [SYM_W-1:0] TAG_JOIN = 8'h30;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_TOPO  = 2'd1,
        OP_DATA  = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_UNDERFLOW = 2'd1,
        STAT_NO_TREE   = 2'd2
    } status_t;

    typedef struct packed {
        logic               leaf;
        logic [NODE_AW-1:0] left;
        logic [NODE_AW-1:0] right;
        logic [SYM_W-1:0]   sym;
    } node_t;

    typedef struct packed {
        logic [SYM_W-1:0] sym;
        status_t          status;
    } result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_JOIN,
        S_POP,
        S_ROOT,
        S_BIT,
        S_CHILD,
        S_FLUSH
    } state_t;

    // an index past the store reads entry 0
    function automatic logic [NODE_AW-1:0] node_addr(input logic [NODE_AW-1:0] idx);
        logic [NODE_AW-1:0] res;
        res = (int'(idx) >= NODE_DEPTH) ? '0 : idx;
        return res;
    endfunction

    function automatic logic [NODE_AW-1:0] child_of(input node_t n, input logic dir);
        logic [NODE_AW-1:0] res;
        res = dir ? n.right : n.left;
        return res;
    endfunction

endpackage

[hdl/htd_item_if.sv]
// htd_item_if: input channel, one beat per opcode item
// depends on htd_pkg for field widths

interface htd_item_if;
    import htd_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        opcode;
    logic [SYM_W-1:0]  byte_value;
    logic [BITS_W-1:0] valid_bits;

    modport source (output valid, output opcode, output byte_value, output valid_bits,
                    input ready);
    modport sink   (input valid, input opcode, input byte_value, input valid_bits,
                    output ready);
endinterface

[hdl/htd_result_if.sv]
// htd_result_if: output channel, one beat per decoded symbol or status flag
// depends on htd_pkg for field widths

interface htd_result_if;
    import htd_pkg::*;

    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] symbol;
    logic             last_of_run;
    logic [1:0]       status;

    modport source (output valid, output symbol, output last_of_run, output status,
                    input ready);
    modport sink   (input valid, input symbol, input last_of_run, input status,
                    output ready);
endinterface

[hdl/huffman_tree_load_and_decode.sv]
// huffman_tree_load_and_decode: postfix tree loader and bit-serial tree walker
// depends on htd_pkg, htd_item_if, htd_result_if
//
// channel | dir | beat carries
// item    | in  | opcode, byte_value, valid_bits
// result  | out | symbol, last_of_run, status
//
// clear, leaf and ignored bytes are taken in S_IDLE; a join also writes its node in S_JOIN
// data byte: walked bit by bit through the node store read port (S_BIT, S_CHILD), after
//   a root pop (S_POP) and root fetch (S_ROOT) after loading; S_FLUSH sends the held result
// one decoded symbol is held back so the final beat can carry last_of_run
// result stalls only hold the walk when a second symbol needs the held slot
// reset is asynchronous; node store and stack contents are not cleared

module huffman_tree_load_and_decode (
    input logic           clk,
    input logic           rst_n,
    htd_item_if.sink      item,
    htd_result_if.source  result
);
    import htd_pkg::*;

    state_t                 state_reg, state_next;
    logic [NODE_CW-1:0]     node_count_reg, node_count_next;
    logic [STACK_LW-1:0]    stack_level_reg, stack_level_next;
    logic                   awaiting_reg, awaiting_next;
    logic                   tree_ready_reg, tree_ready_next;
    logic [BITS_W-1:0]      bits_left_reg, bits_left_next;
    logic [BYTE_BITS-1:0]   data_reg, data_next;
    node_t                  walk_node_reg, walk_node_next;
    node_t                  root_node_reg, root_node_next;
    logic                   pend_valid_reg, pend_valid_next;
    result_t                pend_reg, pend_next;
    logic                   out_valid_reg, out_valid_next;
    result_t                out_reg, out_next;
    logic                   out_last_reg, out_last_next;

    node_t                  node_mem [NODE_DEPTH];
    node_t                  node_rd_reg;
    logic                   node_we, node_re;
    logic [NODE_AW-1:0]     node_waddr, node_raddr;
    node_t                  node_wdata;

    logic [NODE_AW-1:0]     stack_mem [STACK_DEPTH];
    logic [NODE_AW-1:0]     stack_rd_a_reg, stack_rd_b_reg;
    logic                   stack_we, stack_re;
    logic [STACK_AW-1:0]    stack_waddr, stack_raddr_a, stack_raddr_b;
    logic [NODE_AW-1:0]     stack_wdata;

    logic                   emit_req;
    logic [SYM_W-1:0]       emit_sym;
    logic                   slot_free;
    logic                   go;
    node_t                  next_walk;

    assign item.ready         = (state_reg == S_IDLE);
    assign result.valid       = out_valid_reg;
    assign result.symbol      = out_reg.sym;
    assign result.status      = out_reg.status;
    assign result.last_of_run = out_last_reg;

    assign slot_free = !out_valid_reg || result.ready;
    assign emit_req  = ((state_reg == S_BIT) && (bits_left_reg != '0) && walk_node_reg.leaf)
                    || ((state_reg == S_CHILD) && node_rd_reg.leaf);
    assign emit_sym  = (state_reg == S_CHILD) ? node_rd_reg.sym : walk_node_reg.sym;
    assign go        = !emit_req || !pend_valid_reg || slot_free;
    assign next_walk = node_rd_reg.leaf ? root_node_reg : node_rd_reg;

    always_comb
    begin
        state_next       = state_reg;
        node_count_next  = node_count_reg;
        stack_level_next = stack_level_reg;
        awaiting_next    = awaiting_reg;
        tree_ready_next  = tree_ready_reg;
        bits_left_next   = bits_left_reg;
        data_next        = data_reg;
        walk_node_next   = walk_node_reg;
        root_node_next   = root_node_reg;
        pend_valid_next  = pend_valid_reg;
        pend_next        = pend_reg;
        out_valid_next   = out_valid_reg && !result.ready;
        out_next         = out_reg;
        out_last_next    = out_last_reg;
        node_we          = 1'b0;
        node_waddr       = node_count_reg[NODE_AW-1:0];
        node_wdata       = '0;
        node_re          = 1'b0;
        node_raddr       = '0;
        stack_we         = 1'b0;
        stack_waddr      = stack_level_reg[STACK_AW-1:0];
        stack_wdata      = node_count_reg[NODE_AW-1:0];
        stack_re         = 1'b0;
        stack_raddr_a    = STACK_AW'(stack_level_reg - STACK_LW'(1));
        stack_raddr_b    = STACK_AW'(stack_level_reg - STACK_LW'(2));

        case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    case (item.opcode)
                        OP_CLEAR:
                        begin
                            node_count_next  = '0;
                            stack_level_next = '0;
                            awaiting_next    = 1'b0;
                            tree_ready_next  = 1'b0;
                        end
                        OP_TOPO:
                        begin
                            tree_ready_next = 1'b0;
                            if (awaiting_reg)
                            begin
                                awaiting_next = 1'b0;
                                if ((node_count_reg < NODE_CW'(NODE_DEPTH))
                                    && (stack_level_reg < STACK_LW'(STACK_DEPTH)))
                                begin
                                    node_we          = 1'b1;
                                    node_wdata       = '{leaf: 1'b1, left: '0, right: '0,
                                                         sym: item.byte_value};
                                    stack_we         = 1'b1;
                                    node_count_next  = node_count_reg + NODE_CW'(1);
                                    stack_level_next = stack_level_reg + STACK_LW'(1);
                                end
                            end
                            else if (item.byte_value == TAG_LEAF)
                            begin
                                awaiting_next = 1'b1;
                            end
                            else if (item.byte_value == TAG_JOIN)
                            begin
                                if (stack_level_reg < STACK_LW'(2))
                                begin
                                    pend_valid_next = 1'b1;
                                    pend_next       = '{sym: '0, status: STAT_UNDERFLOW};
                                    state_next      = S_FLUSH;
                                end
                                else if (node_count_reg < NODE_CW'(NODE_DEPTH))
                                begin
                                    stack_re   = 1'b1;
                                    state_next = S_JOIN;
                                end
                            end
                        end
                        OP_DATA:
                        begin
                            bits_left_next = (item.valid_bits > BITS_W'(BYTE_BITS))
                                           ? BITS_W'(BYTE_BITS) : item.valid_bits;
                            data_next      = item.byte_value;
                            if (tree_ready_reg)
                            begin
                                state_next = S_BIT;
                            end
                            else if (stack_level_reg == '0)
                            begin
                                pend_valid_next = 1'b1;
                                pend_next       = '{sym: '0, status: STAT_NO_TREE};
                                state_next      = S_FLUSH;
                            end
                            else
                            begin
                                stack_level_next = stack_level_reg - STACK_LW'(1);
                                stack_re         = 1'b1;
                                state_next       = S_POP;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_JOIN:
            begin
                node_we          = 1'b1;
                node_wdata       = '{leaf: 1'b0, left: stack_rd_b_reg, right: stack_rd_a_reg,
                                     sym: '0};
                stack_we         = 1'b1;
                stack_waddr      = stack_raddr_b;
                node_count_next  = node_count_reg + NODE_CW'(1);
                stack_level_next = stack_level_reg - STACK_LW'(1);
                state_next       = S_IDLE;
            end
            S_POP:
            begin
                node_re         = 1'b1;
                node_raddr      = node_addr(stack_rd_a_reg);
                tree_ready_next = 1'b1;
                state_next      = S_ROOT;
            end
            S_ROOT:
            begin
                root_node_next = node_rd_reg;
                walk_node_next = node_rd_reg;
                state_next     = S_BIT;
            end
            S_BIT:
            begin
                if (bits_left_reg == '0)
                begin
                    state_next = S_FLUSH;
                end
                else if (walk_node_reg.leaf)
                begin
                    // root is a leaf: every bit gives its symbol
                    if (go)
                    begin
                        bits_left_next = bits_left_reg - BITS_W'(1);
                        data_next      = {data_reg[BYTE_BITS-2:0], 1'b0};
                    end
                end
                else
                begin
                    node_re        = 1'b1;
                    node_raddr     = node_addr(child_of(walk_node_reg, data_reg[BYTE_BITS-1]));
                    bits_left_next = bits_left_reg - BITS_W'(1);
                    data_next      = {data_reg[BYTE_BITS-2:0], 1'b0};
                    state_next     = S_CHILD;
                end
            end
            S_CHILD:
            begin
                if (go)
                begin
                    walk_node_next = next_walk;
                    if (bits_left_reg == '0)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        node_re        = 1'b1;
                        node_raddr     = node_addr(child_of(next_walk, data_reg[BYTE_BITS-1]));
                        bits_left_next = bits_left_reg - BITS_W'(1);
                        data_next      = {data_reg[BYTE_BITS-2:0], 1'b0};
                    end
                end
            end
            S_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_next        = pend_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // held symbol moves out once another one follows it, or in S_FLUSH
        if (emit_req && go)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = pend_reg;
                out_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_next       = '{sym: emit_sym, status: STAT_OK};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            node_count_reg  <= '0;
            stack_level_reg <= '0;
            awaiting_reg    <= 1'b0;
            tree_ready_reg  <= 1'b0;
            bits_left_reg   <= '0;
            pend_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            node_count_reg  <= node_count_next;
            stack_level_reg <= stack_level_next;
            awaiting_reg    <= awaiting_next;
            tree_ready_reg  <= tree_ready_next;
            bits_left_reg   <= bits_left_next;
            pend_valid_reg  <= pend_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg      <= data_next;
        walk_node_reg <= walk_node_next;
        root_node_reg <= root_node_next;
        pend_reg      <= pend_next;
        out_reg       <= out_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_waddr] <= node_wdata;
        end
        if (node_re)
        begin
            node_rd_reg <= node_mem[node_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[stack_waddr] <= stack_wdata;
        end
        if (stack_re)
        begin
            stack_rd_a_reg <= stack_mem[stack_raddr_a];
            stack_rd_b_reg <= stack_mem[stack_raddr_b];
        end
    end

`ifndef SYNTH
    a_idle_no_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !pend_valid_reg)
        else $error("held result left over in idle");

    a_level_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (stack_level_reg <= STACK_LW'(STACK_DEPTH)) && (node_count_reg <= NODE_CW'(NODE_DEPTH)))
        else $error("stack level or node count out of range");

    a_join_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_JOIN) |-> (stack_level_reg >= STACK_LW'(2)))
        else $error("join with fewer than two stacked nodes");

    a_walk_has_tree: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_BIT) || (state_reg == S_CHILD)) |-> tree_ready_reg)
        else $error("tree walk without a root");

    a_root_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP) |=> (state_reg == S_ROOT))
        else $error("root fetch skipped after pop");
`endif

endmodule

[sim/tb_huffman_tree_load_and_decode.sv]
// tb_huffman_tree_load_and_decode: self-checking bench for the huffman tree loader and decoder
// builds trees in postfix form, decodes packed bits and checks every result beat in order
// depends on htd_pkg, htd_item_if, htd_result_if and the huffman_tree_load_and_decode rtl

module tb_huffman_tree_load_and_decode;
    import htd_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 200;
    localparam int MAX_REPORTS  = 10;
    localparam int RANDOM_ITEMS = 120;

    typedef struct {
        logic [SYM_W-1:0] symbol;
        logic             last;
        status_t          status;
    } beat_t;

    logic clk = 1'b0;
    logic rst_n;

    htd_item_if   item_ch ();
    htd_result_if result_ch ();

    huffman_tree_load_and_decode DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // decoder state as seen from the ports
    node_t              tree_mem [NODE_DEPTH];
    logic [NODE_AW-1:0] stack_mem [STACK_DEPTH];
    int                 n_nodes;
    int                 stacked;
    bit                 want_sym;
    logic [NODE_AW-1:0] root;
    logic [NODE_AW-1:0] walk;
    bit                 loaded;

    beat_t symbols_due [$];
    int    errors     = 0;
    int    burst_left = 0;
    int    gap_max    = 8;
    int    n_sent     = 0;
    bit    hold_req   = 1'b0;

    function automatic void queue_beat(input logic [SYM_W-1:0] sym, input status_t st,
                                       input logic last);
        beat_t b;
        b.symbol = sym;
        b.last   = last;
        b.status = st;
        symbols_due.push_back(b);
    endfunction

    function automatic void decode_step(input logic [1:0] op, input logic [SYM_W-1:0] b,
                                        input logic [BITS_W-1:0] nb);
        node_t nd;
        int    first;
        int    bits;
        int    i;
        first = symbols_due.size();
        case (op)
            OP_CLEAR:
            begin
                n_nodes  = 0;
                stacked  = 0;
                want_sym = 1'b0;
                root     = '0;
                walk     = '0;
                loaded   = 1'b0;
            end
            OP_TOPO:
            begin
                loaded = 1'b0;
                if (want_sym)
                begin
                    want_sym = 1'b0;
                    if (n_nodes < NODE_DEPTH && stacked < STACK_DEPTH)
                    begin
                        nd.leaf  = 1'b1;
                        nd.left  = '0;
                        nd.right = '0;
                        nd.sym   = b;
                        tree_mem[n_nodes] = nd;
                        stack_mem[stacked] = n_nodes[NODE_AW-1:0];
                        stacked++;
                        n_nodes++;
                    end
                end
                else if (b == TAG_LEAF)
                    want_sym = 1'b1;
                else if (b == TAG_JOIN)
                begin
                    if (stacked < 2)
                        queue_beat('0, STAT_UNDERFLOW, 1'b1);
                    else if (n_nodes < NODE_DEPTH)
                    begin
                        nd.leaf  = 1'b0;
                        nd.left  = stack_mem[stacked-2];
                        nd.right = stack_mem[stacked-1];
                        nd.sym   = '0;
                        tree_mem[n_nodes] = nd;
                        stack_mem[stacked-2] = n_nodes[NODE_AW-1:0];
                        stacked--;
                        n_nodes++;
                    end
                end
            end
            OP_DATA:
            begin
                if (!loaded && stacked == 0)
                    queue_beat('0, STAT_NO_TREE, 1'b1);
                else
                begin
                    if (!loaded)
                    begin
                        stacked--;
                        root   = stack_mem[stacked];
                        walk   = root;
                        loaded = 1'b1;
                    end
                    bits = (nb > BYTE_BITS) ? BYTE_BITS : int'(nb);
                    for (i = 0; i < bits; i++)
                    begin
                        nd = tree_mem[walk];
                        if (nd.leaf)
                        begin
                            queue_beat(nd.sym, STAT_OK, 1'b0);
                            walk = root;
                        end
                        else
                        begin
                            walk = b[BYTE_BITS-1-i] ? nd.right : nd.left;
                            nd = tree_mem[walk];
                            if (nd.leaf)
                            begin
                                queue_beat(nd.sym, STAT_OK, 1'b0);
                                walk = root;
                            end
                        end
                    end
                    if (symbols_due.size() > first)
                        symbols_due[$].last = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [SYM_W-1:0] b,
                             input logic [BITS_W-1:0] nb);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        item_ch.valid      <= 1'b1;
        item_ch.opcode     <= op;
        item_ch.byte_value <= b;
        item_ch.valid_bits <= nb;
        do
            @(posedge clk);
        while (item_ch.ready !== 1'b1);
        n_sent++;
        decode_step(op, b, nb);
    endtask

    task automatic send_leaf(input logic [SYM_W-1:0] sym);
        send_item(OP_TOPO, TAG_LEAF, BITS_W'($urandom_range(0, 15)));
        send_item(OP_TOPO, sym, BITS_W'($urandom_range(0, 15)));
    endtask

    task automatic send_join();
        send_item(OP_TOPO, TAG_JOIN, BITS_W'($urandom_range(0, 15)));
    endtask

    function automatic logic [BITS_W-1:0] pick_bits();
        logic [BITS_W-1:0] nb;
        nb = ($urandom_range(0, 9) < 7) ? BITS_W'(BYTE_BITS) : BITS_W'($urandom_range(0, 15));
        return nb;
    endfunction

    task automatic test_no_tree();
        send_item(OP_DATA, 8'hFF, 4'd8);
        send_join();
        send_item(OP_TOPO, 8'hFF, 4'd15);
        send_item(OP_UNUSED, 8'hA5, 4'd8);
        send_item(OP_DATA, 8'h00, 4'd1);
    endtask

    task automatic test_small_tree();
        send_item(OP_CLEAR, 8'h00, 4'd0);
        send_leaf(8'h00);
        send_leaf(8'hFF);
        send_join();
        send_leaf(TAG_LEAF);
        send_join();
        send_item(OP_DATA, 8'hFF, 4'd8);
        send_item(OP_DATA, 8'h55, 4'd15);
        send_item(OP_DATA, 8'h80, 4'd1);
        send_item(OP_DATA, 8'h00, 4'd1);
        send_item(OP_DATA, 8'h00, 4'd0);
        send_item(OP_DATA, 8'h00, 4'd1);
        // data between tag and symbol, with the stack already empty
        send_item(OP_TOPO, TAG_LEAF, 4'd0);
        send_item(OP_DATA, 8'hC0, 4'd2);
        send_item(OP_TOPO, TAG_JOIN, 4'd0);
        send_item(OP_DATA, 8'h40, 4'd3);
        // join with a single entry stacked
        send_item(OP_CLEAR, 8'h00, 4'd0);
        send_leaf(8'h7E);
        send_join();
        send_item(OP_DATA, 8'hFF, 4'd4);
    endtask

    task automatic test_random_streams(input int budget);
        int               start;
        int               leaves;
        int               open_cnt;
        int               n_data;
        int               r;
        int               i;
        logic [SYM_W-1:0] b;
        start = n_sent;
        while (n_sent - start < budget)
        begin
            if ($urandom_range(0, 9) != 0)
                send_item(OP_CLEAR, SYM_W'($urandom), BITS_W'($urandom_range(0, 15)));
            r = $urandom_range(0, 9);
            leaves = (r == 0) ? 1 : (r < 8) ? $urandom_range(2, 8) : $urandom_range(9, 40);
            open_cnt = 0;
            while (leaves > 0 || open_cnt > 1)
            begin
                r = $urandom_range(0, 29);
                if (r == 0)
                begin
                    do
                        b = SYM_W'($urandom);
                    while (b == TAG_LEAF || b == TAG_JOIN);
                    send_item(OP_TOPO, b, BITS_W'($urandom_range(0, 15)));
                end
                else if (r == 1)
                    send_item(OP_UNUSED, SYM_W'($urandom), BITS_W'($urandom_range(0, 15)));
                else if (r == 2)
                    send_item(OP_DATA, SYM_W'($urandom), pick_bits());
                else if (r == 3)
                    send_join();
                if (leaves > 0 && (open_cnt < 2 || $urandom_range(0, 1) == 0))
                begin
                    r = $urandom_range(0, 9);
                    b = (r == 0) ? TAG_LEAF : (r == 1) ? TAG_JOIN : SYM_W'($urandom);
                    send_leaf(b);
                    leaves--;
                    open_cnt++;
                end
                else
                begin
                    send_join();
                    open_cnt--;
                end
            end
            n_data = $urandom_range(2, 8);
            for (i = 0; i < n_data; i++)
                send_item(OP_DATA, SYM_W'($urandom), pick_bits());
        end
    endtask

    task automatic test_backpressure();
        int i;
        int saved_gap;
        saved_gap = gap_max;
        gap_max = 0;
        send_item(OP_CLEAR, 8'h00, 4'd0);
        send_leaf(SYM_W'($urandom));
        hold_req = 1'b1;
        for (i = 0; i < 40; i++)
            send_item(OP_DATA, SYM_W'($urandom), 4'd8);
        gap_max = saved_gap;
    endtask

    always @(posedge clk)
    begin : result_check
        beat_t due;
        if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            if (symbols_due.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("mismatch: unexpected beat sym=%02h last=%0b status=%0d",
                             result_ch.symbol, result_ch.last_of_run, result_ch.status);
            end
            else
            begin
                due = symbols_due.pop_front();
                if (result_ch.symbol !== due.symbol || result_ch.last_of_run !== due.last
                    || result_ch.status !== due.status)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("mismatch: exp %02h/%0b/%0d got %02h/%0b/%0d",
                                 due.symbol, due.last, due.status, result_ch.symbol,
                                 result_ch.last_of_run, result_ch.status);
                end
            end
        end
    end

    initial
    begin : result_sink
        int mode;
        int span;
        int hold_cnt;
        mode = 0;
        span = 0;
        hold_cnt = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_cnt = HOLD_CYCLES;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                if (span == 0)
                begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(5, 60);
                end
                span--;
                case (mode)
                    0:       result_ch.ready <= 1'b1;
                    1:       result_ch.ready <= 1'($urandom_range(0, 1));
                    2:       result_ch.ready <= ($urandom_range(0, 3) != 0);
                    default: result_ch.ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if (rst_n !== 1'b1 || (item_ch.valid === 1'b1 && item_ch.ready === 1'b1)
                || (result_ch.valid === 1'b1 && result_ch.ready === 1'b1))
                idle = 0;
            else
                idle++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : run
        n_nodes  = 0;
        stacked  = 0;
        want_sym = 1'b0;
        root     = '0;
        walk     = '0;
        loaded   = 1'b0;
        rst_n              <= 1'b0;
        item_ch.valid      <= 1'b0;
        item_ch.opcode     <= OP_CLEAR;
        item_ch.byte_value <= '0;
        item_ch.valid_bits <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_no_tree();
        test_small_tree();
        test_random_streams(RANDOM_ITEMS);
        test_backpressure();
        test_random_streams(RANDOM_ITEMS);

        item_ch.valid <= 1'b0;
        while (symbols_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && symbols_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
